/* design/rc_command_frame_builder_top_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the RC command frame builder
// ---------------------------------------------------------------------------
`ifndef RC_COMMAND_FRAME_BUILDER_TOP_MACROS_SVH
`define RC_COMMAND_FRAME_BUILDER_TOP_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define RCFB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rc frame builder check failed");

// next-cycle implication
`define RCFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rc frame builder check failed");

`endif

/* design/rcfb_pkg.sv */
// ---------------------------------------------------------------------------
// rcfb_pkg
// Types and constants shared by the RC command frame builder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcfb_pkg;

    localparam int FRAME_LEN   = 22;
    localparam int NUM_CHAN    = 8;
    localparam int CFG_INDEX_W = 2;

    localparam logic [7:0] HDR_DOLLAR  = 8'h24;
    localparam logic [7:0] HDR_M       = 8'h4D;
    localparam logic [7:0] HDR_DIR     = 8'h3C;
    localparam logic [7:0] PAYLOAD_LEN = 8'd16;

    localparam logic [15:0] LOW_LIMIT_RST  = 16'd1000;
    localparam logic [15:0] HIGH_LIMIT_RST = 16'd2000;
    localparam logic [15:0] NEUTRAL_RST    = 16'd1500;
    localparam logic [7:0]  COMMAND_RST    = 8'd200;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LOW_LIMIT  = 2'd0,
        REG_HIGH_LIMIT = 2'd1,
        REG_NEUTRAL    = 2'd2,
        REG_COMMAND    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] low_limit;
        logic [15:0] high_limit;
        logic [15:0] neutral;
        logic [7:0]  command;
    } rc_cfg_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } cell_data_t;

endpackage

/* design/rcfb_cell.sv */
// ---------------------------------------------------------------------------
// rcfb_cell
// One byte cell of the output chain: loads in parallel, shifts towards the head.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcfb_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  logic                shift,
    input  rcfb_pkg::cell_data_t load_data,
    input  logic                nb_valid,
    input  rcfb_pkg::cell_data_t nb_data,
    output logic                valid,
    output rcfb_pkg::cell_data_t data
);
    import rcfb_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    cell_data_t data_reg;
    cell_data_t data_next;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = load_data;
        end else if (shift) begin
            // take over the neighbour's byte
            valid_next = nb_valid;
            data_next  = nb_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

/* design/rcfb_frame_gen.sv */
// ---------------------------------------------------------------------------
// rcfb_frame_gen
// Builds the 22 bytes of one set-raw-RC request from the throttle and config.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcfb_frame_gen (
    input  logic signed [11:0]   throttle_tenths,
    input  rcfb_pkg::rc_cfg_t    cfg,
    output rcfb_pkg::cell_data_t frame [rcfb_pkg::FRAME_LEN]
);
    import rcfb_pkg::*;

    logic signed [17:0] thr_sum;
    logic signed [17:0] low_s;
    logic signed [17:0] high_s;
    logic [15:0]        thr_val;
    logic [15:0]        aux1_val;
    logic [15:0]        chan [NUM_CHAN];
    logic [7:0]         bytes [FRAME_LEN];
    logic [7:0]         csum;

    always_comb begin
        low_s   = $signed({2'b00, cfg.low_limit});
        high_s  = $signed({2'b00, cfg.high_limit});
        thr_sum = low_s + 18'(throttle_tenths);

        // high clamp first, low clamp second
        thr_val = thr_sum[15:0];
        if (thr_sum > high_s) begin
            thr_val = cfg.high_limit;
        end
        if ((thr_sum > high_s ? high_s : thr_sum) < low_s) begin
            thr_val = cfg.low_limit;
        end

        aux1_val = (throttle_tenths > 12'sd0) ? cfg.high_limit : cfg.low_limit;

        chan[0] = cfg.neutral;
        chan[1] = cfg.neutral;
        chan[2] = thr_val;
        chan[3] = cfg.neutral;
        chan[4] = aux1_val;
        chan[5] = cfg.low_limit;
        chan[6] = cfg.low_limit;
        chan[7] = cfg.low_limit;

        bytes[0] = HDR_DOLLAR;
        bytes[1] = HDR_M;
        bytes[2] = HDR_DIR;
        bytes[3] = PAYLOAD_LEN;
        bytes[4] = cfg.command;
        for (int c = 0; c < NUM_CHAN; c++) begin
            bytes[5 + 2*c]     = chan[c][7:0];
            bytes[5 + 2*c + 1] = chan[c][15:8];
        end

        csum = 8'h00;
        for (int i = 3; i < FRAME_LEN - 1; i++) begin
            csum = csum ^ bytes[i];
        end
        bytes[FRAME_LEN-1] = csum;

        for (int i = 0; i < FRAME_LEN; i++) begin
            frame[i].data = bytes[i];
            frame[i].last = (i == FRAME_LEN - 1);
        end
    end

endmodule

/* design/rc_command_frame_builder_top.sv */
// The first frame byte goes from chain cell 0 through the output register onto m_tdata.
// One frame byte per cycle while m_tready holds, set by the 22-cell byte chain that
// drains one cell per cycle into the output register, unless m_tready stalls it.
// A new request is taken in the cycle the last byte of the previous frame leaves the chain.
// Reset (aresetn low, synchronous) empties the chain and output register and
// restores the registers to low 1000, high 2000, neutral 1500, command 200.
// ---------------------------------------------------------------------------
// rc_command_frame_builder_top
// Throttle request in, 22-byte set-raw-RC request frame out, one byte a beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc_command_frame_builder_top (
    input  logic        aclk,
    input  logic        aresetn,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // request in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] throttle_tenths, [15:12] zero
    // frame bytes out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] frame_byte
    output logic        m_tlast    // last_byte
);
    import rcfb_pkg::*;

    rc_cfg_t    cfg_reg;
    rc_cfg_t    cfg_next;
    cell_data_t frame     [FRAME_LEN];
    cell_data_t cell_q    [FRAME_LEN];
    logic       cell_vld  [FRAME_LEN];
    logic       advance;
    logic       load;
    logic       out_valid_reg;
    logic       out_valid_next;
    cell_data_t out_reg;
    cell_data_t out_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_LOW_LIMIT:  cfg_next.low_limit  = cfg_data;
                REG_HIGH_LIMIT: cfg_next.high_limit = cfg_data;
                REG_NEUTRAL:    cfg_next.neutral    = cfg_data;
                REG_COMMAND:    cfg_next.command    = cfg_data[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_limit  <= LOW_LIMIT_RST;
            cfg_reg.high_limit <= HIGH_LIMIT_RST;
            cfg_reg.neutral    <= NEUTRAL_RST;
            cfg_reg.command    <= COMMAND_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rcfb_frame_gen u_frame_gen (
        .throttle_tenths ($signed(s_tdata[11:0])),
        .cfg             (cfg_reg),
        .frame           (frame)
    );

    // head byte moves out whenever the output register is free or being drained
    assign advance  = cell_vld[0] && (!out_valid_reg || m_tready);
    // load when at most the head byte is left and it leaves this cycle
    assign s_tready = !cell_vld[1] && (!cell_vld[0] || advance);
    assign load     = s_tvalid && s_tready;

    for (genvar i = 0; i < FRAME_LEN; i++) begin : g_cell
        logic       nb_vld;
        cell_data_t nb_q;
        if (i == FRAME_LEN - 1) begin : g_tail
            assign nb_vld = 1'b0;
            assign nb_q   = '0;
        end else begin : g_mid
            assign nb_vld = cell_vld[i+1];
            assign nb_q   = cell_q[i+1];
        end
        rcfb_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .load      (load),
            .shift     (advance),
            .load_data (frame[i]),
            .nb_valid  (nb_vld),
            .nb_data   (nb_q),
            .valid     (cell_vld[i]),
            .data      (cell_q[i])
        );
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance) begin
            out_valid_next = 1'b1;
            out_next       = cell_q[0];
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tlast  = out_reg.last;

endmodule

/* design/rcfb_checker.sv */
// ---------------------------------------------------------------------------
// rcfb_checker
// Port-level checks on the frame builder, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rc_command_frame_builder_top_macros.svh"

module rcfb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);
    import rcfb_pkg::*;

    logic [4:0] cnt_reg;
    logic [4:0] cnt_next;
    logic       at_tail;
    logic       at_head;

    // count delivered bytes within the current frame
    always_comb begin
        cnt_next = cnt_reg;
        if (m_tvalid && m_tready) begin
            cnt_next = m_tlast ? 5'd0 : cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 5'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign at_tail = (cnt_reg == 5'(FRAME_LEN - 1));
    assign at_head = (cnt_reg == 5'd0);

    `RCFB_ASSERT_NOW(a_last_on_tail, aclk, aresetn, m_tvalid, m_tlast == at_tail)
    `RCFB_ASSERT_NOW(a_frame_starts_dollar, aclk, aresetn, m_tvalid && at_head, m_tdata == HDR_DOLLAR)
    `RCFB_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `RCFB_ASSERT_NEXT(a_hold_when_stalled, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind rc_command_frame_builder_top rcfb_checker u_rcfb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
